@@ hdl/htab_pkg.sv @@
package htab_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int GEN_W = 32;
  localparam int CAP_W = 11;

  // Capacity after reset: 1024 slots, or the whole table if it is smaller.
  localparam int CAP_RESET = (TABLE_DEPTH < 1024) ? TABLE_DEPTH : 1024;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOENT = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [IDX_W-1:0]         handle_index;
    logic [GEN_W-1:0]         handle_generation;
    logic [PAYLOAD_WIDTH-1:0] entry_payload;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [IDX_W-1:0]         out_index;
    logic [GEN_W-1:0]         out_generation;
    logic [PAYLOAD_WIDTH-1:0] out_payload;
    logic [CNT_W-1:0]         used_count;
  } rsp_t;

  typedef struct packed {
    logic                     occupied;
    logic [GEN_W-1:0]         generation;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } slot_entry_t;

  // Control from the register block to the table logic.
  typedef struct packed {
    logic             init;
    logic [CNT_W-1:0] init_capacity;
    logic [CNT_W-1:0] capacity;
  } cfg_t;

endpackage

@@ hdl/generational_handle_table_top.sv @@
// Handle table: allocate, lookup and release of generational handles. Inside
// the block each command beat first reads the free stack memory, then reads
// the slot memory (index, generation, payload), and last checks, writes back
// and loads the result register; a new beat is taken only once the previous
// one has left that last step, and a held result stalls the write-back. The
// result register lets the next beat enter while the previous result still
// waits. Writing the capacity register re-initializes the table at once with
// no clearing pass: slots that were never handed out since the write are
// tracked by a low-water mark of the free stack.
module generational_handle_table_top import htab_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT,
    S_EXEC
  } state_t;

  state_t           state;
  cfg_t             cfg;
  req_t             cur;
  logic [CNT_W-1:0] stack_top;
  logic [CNT_W-1:0] low_mark;
  logic [CNT_W-1:0] used_slots;
  logic [IDX_W-1:0] cur_slot;
  logic             cur_fresh;

  logic [CNT_W-1:0] top_dec;
  logic [CNT_W-1:0] fresh_slot;
  logic [CNT_W-1:0] fresh_count;
  logic             is_fresh;
  logic [IDX_W-1:0] slot_sel;
  logic             accept;
  logic             exec_go;
  logic [IDX_W-1:0] stack_rdata;
  logic             stack_we;
  slot_entry_t      slot_rd;
  slot_entry_t      slot_wd;
  logic             slot_we;
  logic             handle_ok;
  logic [GEN_W-1:0] alloc_gen;
  rsp_t             rsp_next;
  logic [CNT_W-1:0] stack_top_next;
  logic [CNT_W-1:0] low_mark_next;
  logic [CNT_W-1:0] used_slots_next;

  htab_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign exec_go   = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  assign top_dec     = stack_top - CNT_W'(1);
  assign fresh_slot  = cfg.capacity - stack_top;
  assign fresh_count = cfg.capacity - low_mark;
  // Stack entries below the low-water mark were never written since the last
  // re-initialization; their content is ignored and the slot comes from the stack top.
  assign is_fresh    = (stack_top == low_mark);

  always_comb begin
    if (cur.cmd == CMD_ALLOC) begin
      slot_sel = is_fresh ? fresh_slot[IDX_W-1:0] : stack_rdata;
    end else begin
      slot_sel = cur.handle_index;
    end
  end

  htab_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_top[IDX_W-1:0]),
    .wdata (cur.handle_index),
    .re    (accept),
    .raddr (top_dec[IDX_W-1:0]),
    .rdata (stack_rdata)
  );

  htab_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (cur_slot),
    .wdata (slot_wd),
    .re    (state == S_SLOT),
    .raddr (slot_sel),
    .rdata (slot_rd)
  );

  // Slots never handed out since re-initialization are free with generation 1.
  assign handle_ok = (CNT_W'(cur.handle_index) < cfg.capacity) &&
                     (CNT_W'(cur.handle_index) < fresh_count) &&
                     slot_rd.occupied &&
                     (slot_rd.generation == cur.handle_generation);
  assign alloc_gen = cur_fresh ? GEN_W'(1) : slot_rd.generation;

  always_comb begin
    slot_we         = 1'b0;
    slot_wd         = slot_rd;
    stack_we        = 1'b0;
    stack_top_next  = stack_top;
    low_mark_next   = low_mark;
    used_slots_next = used_slots;
    rsp_next                = '0;
    rsp_next.status         = ST_NOENT;
    case (cur.cmd)
      CMD_ALLOC: begin
        if (stack_top != '0 && stack_top <= cfg.capacity) begin
          slot_we            = exec_go;
          slot_wd.occupied   = 1'b1;
          slot_wd.generation = alloc_gen;
          slot_wd.payload    = cur.entry_payload;
          stack_top_next     = top_dec;
          if (cur_fresh) begin
            low_mark_next = low_mark - CNT_W'(1);
          end
          if (used_slots < cfg.capacity) begin
            used_slots_next = used_slots + CNT_W'(1);
          end
          rsp_next.status         = ST_OK;
          rsp_next.out_index      = cur_slot;
          rsp_next.out_generation = alloc_gen;
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      CMD_LOOKUP: begin
        if (handle_ok) begin
          rsp_next.status      = ST_OK;
          rsp_next.out_payload = slot_rd.payload;
        end
      end
      CMD_RELEASE: begin
        if (handle_ok) begin
          slot_we            = exec_go;
          slot_wd.occupied   = 1'b0;
          slot_wd.generation = slot_rd.generation + GEN_W'(1);
          if (stack_top < cfg.capacity) begin
            stack_we       = exec_go;
            stack_top_next = stack_top + CNT_W'(1);
          end
          if (used_slots != '0) begin
            used_slots_next = used_slots - CNT_W'(1);
          end
          rsp_next.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    rsp_next.used_count = used_slots_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      stack_top  <= CNT_W'(CAP_RESET);
      low_mark   <= CNT_W'(CAP_RESET);
      used_slots <= '0;
    end else if (cfg.init) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      stack_top  <= cfg.init_capacity;
      low_mark   <= cfg.init_capacity;
      used_slots <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && !exec_go) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur   <= req;
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          cur_slot  <= slot_sel;
          cur_fresh <= is_fresh;
          state     <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            rsp        <= rsp_next;
            rsp_valid  <= 1'b1;
            stack_top  <= stack_top_next;
            low_mark   <= low_mark_next;
            used_slots <= used_slots_next;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/htab_ram.sv @@
module htab_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/htab_cfg.sv @@
module htab_cfg import htab_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [CNT_W-1:0] capacity;
  logic [31:0]      wr_value;
  logic             wr_capacity;

  assign pready = 1'b1;
  assign prdata = APB_DATA_W'(capacity);

  assign wr_value    = 32'(pwdata[CAP_W-1:0]);
  assign wr_capacity = psel && penable && pwrite && pready &&
                       (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);

  // A capacity above the table size saturates to the table size.
  always_comb begin
    cfg.init     = wr_capacity;
    cfg.capacity = capacity;
    if (wr_value > 32'(TABLE_DEPTH)) begin
      cfg.init_capacity = CNT_W'(TABLE_DEPTH);
    end else begin
      cfg.init_capacity = CNT_W'(wr_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(CAP_RESET);
    end else if (wr_capacity) begin
      capacity <= cfg.init_capacity;
    end
  end

endmodule

@@ hdl/htab_checker.sv @@
module htab_checker import htab_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic                  rsp_valid,
  input logic                  rsp_stall,
  input rsp_t                  rsp
);

  // A stalled result beat stays up and unchanged unless a register write comes in.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall && !(psel && penable && pwrite) |=>
      rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // Only a successful command carries a handle or a payload.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |->
      rsp.out_index == '0 && rsp.out_generation == '0 && rsp.out_payload == '0)
    else $error("failed command returned handle or payload bits");

  // The occupied count never exceeds the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.used_count <= CNT_W'(TABLE_DEPTH))
    else $error("used count above table size");

  // No result beat comes out of reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result beat valid right after reset");

endmodule

bind generational_handle_table_top htab_checker u_htab_checker (.*);

@@ tb/tb_generational_handle_table_top.sv @@
module tb_generational_handle_table_top;
  import htab_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 8;

  class handle_table_scoreboard;
    logic                     occupied   [TABLE_DEPTH];
    logic [GEN_W-1:0]         gens       [TABLE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] payloads   [TABLE_DEPTH];
    logic [IDX_W-1:0]         free_list  [TABLE_DEPTH];
    int unsigned              capacity;
    int unsigned              stack_top;
    int unsigned              used_slots;
    int unsigned              live_q [$];
    rsp_t                     expected_q [$];
    int                       errors;

    function new();
      errors = 0;
      reinit(CAP_RESET);
    endfunction

    function void reinit(int unsigned cap);
      if (cap > TABLE_DEPTH) cap = TABLE_DEPTH;
      capacity = cap;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        occupied[i]   = 1'b0;
        gens[i]       = GEN_W'(1);
        payloads[i]   = '0;
        free_list[i]  = (i < cap) ? IDX_W'(cap - 1 - i) : '0;
      end
      stack_top  = cap;
      used_slots = 0;
      live_q.delete();
    endfunction

    function void write_capacity(logic [APB_DATA_W-1:0] value);
      reinit(value[CAP_W-1:0]);
    endfunction

    function bit handle_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
      if (idx >= capacity) return 1'b0;
      if (!occupied[idx]) return 1'b0;
      return gens[idx] == gen;
    endfunction

    function void forget_live(int unsigned idx);
      for (int k = 0; k < live_q.size(); k++) begin
        if (live_q[k] == idx) begin
          live_q.delete(k);
          break;
        end
      end
    endfunction

    // Advances the table state by one accepted request beat and queues the
    // result it must produce.
    function void note_request(req_t item);
      rsp_t             want;
      logic [IDX_W-1:0] slot;
      want = '0;
      want.status = ST_NOENT;
      case (item.cmd)
        CMD_ALLOC: begin
          if (stack_top == 0 || stack_top > capacity) begin
            want.status = ST_FULL;
          end else begin
            stack_top--;
            slot = free_list[stack_top];
            payloads[slot] = item.entry_payload;
            occupied[slot] = 1'b1;
            if (used_slots < capacity) used_slots++;
            live_q.push_back(slot);
            want.out_index      = slot;
            want.out_generation = gens[slot];
            want.status         = ST_OK;
          end
        end
        CMD_LOOKUP: begin
          if (handle_live(item.handle_index, item.handle_generation)) begin
            want.out_payload = payloads[item.handle_index];
            want.status      = ST_OK;
          end
        end
        CMD_RELEASE: begin
          if (handle_live(item.handle_index, item.handle_generation)) begin
            slot = item.handle_index;
            occupied[slot] = 1'b0;
            payloads[slot] = '0;
            gens[slot]     = gens[slot] + 1'b1;
            if (stack_top < capacity) begin
              free_list[stack_top] = slot;
              stack_top++;
            end
            if (used_slots > 0) used_slots--;
            forget_live(slot);
            want.status = ST_OK;
          end
        end
        default: ;
      endcase
      want.used_count = CNT_W'(used_slots);
      expected_q.push_back(want);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no request outstanding: 0x%0h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("status", want.status, got.status);
      check_field("out_index", want.out_index, got.out_index);
      check_field("out_generation", want.out_generation, got.out_generation);
      check_field("out_payload", want.out_payload, got.out_payload);
      check_field("used_count", want.used_count, got.used_count);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp;

  handle_table_scoreboard sb = new();
  int                     gap_pct;
  bit                     hold_request;
  int                     cycle_count;

  generational_handle_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[generational_handle_table_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // Result side: runs of stalls and of free flow, plus one long hold-off on
  // request so that the block backs up into its request port.
  initial begin
    int run_left;
    int roll;
    run_left     = 0;
    hold_request = 1'b0;
    rsp_stall    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
        run_left     = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        roll = $urandom_range(99);
        if (roll < 15) begin
          rsp_stall <= 1'b0;
          run_left = $urandom_range(150, 30);
        end else if (roll < 55) begin
          rsp_stall <= 1'b1;
          run_left = $urandom_range(2, 0);
        end else if (roll < 60) begin
          rsp_stall <= 1'b1;
          run_left = $urandom_range(40, 10);
        end else begin
          rsp_stall <= 1'b0;
          run_left = $urandom_range(4, 0);
        end
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(99) >= gap_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  task automatic send_item(input req_t item);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(item);
  endtask

  task automatic send_fields(input logic [1:0] c, input logic [IDX_W-1:0] idx,
                             input logic [GEN_W-1:0] gen,
                             input logic [PAYLOAD_WIDTH-1:0] pay);
    req_t item;
    item.cmd               = c;
    item.handle_index      = idx;
    item.handle_generation = gen;
    item.entry_payload     = pay;
    send_item(item);
  endtask

  task automatic idle_request();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    idle_request();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity_reg(input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_capacity(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly well-formed traffic on live handles; the rest aims at stale
  // generations, out-of-range indices, free slots and the unused command.
  function automatic req_t random_item(int alloc_pct);
    req_t        item;
    int          roll;
    int          pick;
    int unsigned slot;
    item.cmd               = CMD_ALLOC;
    item.handle_index      = IDX_W'($urandom);
    item.handle_generation = $urandom;
    item.entry_payload     = PAYLOAD_WIDTH'($urandom);
    if ($urandom_range(15) == 0) item.entry_payload = $urandom_range(1) ? '0 : '1;
    roll = $urandom_range(99);
    if (roll < alloc_pct) return item;
    if (roll < 88 && sb.live_q.size() > 0) begin
      pick = $urandom_range(sb.live_q.size() - 1);
      slot = sb.live_q[pick];
      item.cmd               = ($urandom_range(99) < 55) ? CMD_LOOKUP : CMD_RELEASE;
      item.handle_index      = IDX_W'(slot);
      item.handle_generation = sb.gens[slot];
      return item;
    end
    item.cmd = $urandom_range(1) ? CMD_LOOKUP : CMD_RELEASE;
    case ($urandom_range(3))
      0: item.cmd = CMD_UNKNOWN;
      1: begin
        if (sb.capacity > 0) begin
          slot = $urandom_range(sb.capacity - 1);
          item.handle_index      = IDX_W'(slot);
          item.handle_generation = sb.gens[slot] ^ (32'h1 << $urandom_range(GEN_W - 1));
        end
      end
      2: begin
        if (sb.capacity < TABLE_DEPTH) begin
          slot = $urandom_range(TABLE_DEPTH - 1, sb.capacity);
          item.handle_index      = IDX_W'(slot);
          item.handle_generation = sb.gens[slot];
        end
      end
      default: ;
    endcase
    return item;
  endfunction

  task automatic run_phase(input int unsigned cap, input int items, input int alloc_pct,
                           input int gaps, input bit hold, input bit pause);
    settle();
    // Bits above the register width carry noise; they must be ignored.
    write_capacity_reg(($urandom & 32'hffff_f800) | (cap & 32'h0000_07ff));
    gap_pct = gaps;
    if (hold) begin
      @(posedge clk);
      hold_request = 1'b1;
    end
    for (int n = 0; n < items; n++) begin
      if (pause && n == items / 2) begin
        idle_request();
        wait_drained();
      end
      send_item(random_item(alloc_pct));
    end
  endtask

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    req_valid = 1'b0;
    req       = '0;
    gap_pct   = 30;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset capacity: empty table, LIFO reuse, stale and bad handles.
    send_fields(CMD_LOOKUP, '0, 32'd1, '0);
    send_fields(CMD_RELEASE, '0, 32'd1, '0);
    send_fields(CMD_ALLOC, '1, '1, '0);
    send_fields(CMD_ALLOC, '0, '0, '1);
    send_fields(CMD_LOOKUP, '0, 32'd1, '1);
    send_fields(CMD_LOOKUP, 10'd1, 32'd1, '0);
    send_fields(CMD_LOOKUP, 10'd1, 32'd2, '0);
    send_fields(CMD_LOOKUP, 10'd1, '1, '0);
    send_fields(CMD_LOOKUP, '1, 32'd1, '0);
    send_fields(CMD_UNKNOWN, 10'd1, 32'd1, '1);
    send_fields(CMD_RELEASE, '0, 32'd1, '0);
    send_fields(CMD_LOOKUP, '0, 32'd1, '0);
    send_fields(CMD_RELEASE, '0, 32'd1, '0);
    send_fields(CMD_ALLOC, '0, '0, 32'ha5a5_5a5a);
    send_fields(CMD_LOOKUP, '0, 32'd2, '0);
    send_fields(CMD_RELEASE, 10'd1, 32'd1, '0);
    send_fields(CMD_RELEASE, '0, 32'd2, '0);

    run_phase(4, 200, 45, 30, 1'b0, 1'b0);
    run_phase(16, 250, 40, 0, 1'b0, 1'b1);
    run_phase(1, 100, 40, 30, 1'b0, 1'b0);
    run_phase(0, 40, 40, 30, 1'b0, 1'b0);
    run_phase(2047, 300, 60, 10, 1'b1, 1'b0);
    run_phase(1023, 150, 30, 30, 1'b0, 1'b0);
    run_phase($urandom_range(64, 2), 200, 35, 50, 1'b0, 1'b0);
    run_phase(1024, 150, 40, 20, 1'b0, 1'b0);
    run_phase(8, 250, 25, 30, 1'b0, 1'b0);

    settle();
    if (sb.errors == 0) begin
      $display("[generational_handle_table_top] OK");
    end else begin
      $display("[generational_handle_table_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/htab_pkg.sv
hdl/htab_ram.sv
hdl/htab_cfg.sv
hdl/generational_handle_table_top.sv
hdl/htab_checker.sv
tb/tb_generational_handle_table_top.sv
